[design/bpq_pkg.sv]
// shared types and constants for the bucket priority queue
package bpq_pkg;
	localparam int NODE_W = 12;
	localparam int COST_W = 10;
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP = 1'b1;

	typedef struct packed {
		logic kind;
		logic [NODE_W-1:0] node_id;
		logic [COST_W-1:0] cost;
	} req_t;

	typedef struct packed {
		logic found;
		logic [NODE_W-1:0] out_node;
	} rsp_t;
endpackage

[design/bpq_if.sv]
// valid/ready channel carrying one payload
interface bpq_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/bpq_node_mem.sv]
// per-node link memory: next, prev and bucket of every node
module bpq_node_mem #(
	parameter int NW = 12,
	parameter int BW = 11
) (
	input logic clk,
	input logic [NW-1:0] raddr,
	output logic [NW:0] rnext,
	output logic [NW:0] rprev,
	output logic [BW-1:0] rbkt,
	input logic we,
	input logic [NW-1:0] waddr,
	input logic [NW:0] wnext,
	input logic [NW:0] wprev,
	input logic [BW-1:0] wbkt,
	input logic [2:0] wmask
);
	logic [NW:0] next_mem [2**NW];
	logic [NW:0] prev_mem [2**NW];
	logic [BW-1:0] bkt_mem [2**NW];

	// write ports with per-field enables
	always_ff @(posedge clk) begin
		if (we && wmask[0]) next_mem[waddr] <= wnext;
		if (we && wmask[1]) prev_mem[waddr] <= wprev;
		if (we && wmask[2]) bkt_mem[waddr] <= wbkt;
	end

	// registered read
	always_ff @(posedge clk) begin
		rnext <= next_mem[raddr];
		rprev <= prev_mem[raddr];
		rbkt <= bkt_mem[raddr];
	end
endmodule

[design/bucket_priority_queue.sv]
// bucket priority queue top level: sequencer around head and node memories
// push: read node, unlink if queued, read bucket head, set its prev, link node as head
// pop: scan buckets up from the minimum and unlink the head found; an empty queue
// loads an empty result; the next request is taken the cycle after the result is loaded
// one request in flight; a held result only stalls a pop at its result step
// reset: a clearing pass over heads and node buckets, no request taken
module bucket_priority_queue #(
	parameter int COST_LIMIT = 1023,
	parameter int NODES = 4096
) (
	input logic clk,
	input logic arst_n,
	bpq_if.sink req,
	bpq_if.source rsp
);
	localparam int NW = $clog2(NODES);
	localparam int BW = $clog2(COST_LIMIT + 2);
	localparam int HW = $clog2(COST_LIMIT + 1);
	localparam int CW = (NW > HW) ? NW : HW;
	localparam logic [NW:0] NONE = (NW+1)'(NODES);
	localparam logic [BW-1:0] NOTQ = BW'(COST_LIMIT + 1);

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RDN = 4'd2,
		S_UNL = 4'd3, S_FIXA = 4'd4, S_FIXB = 4'd5, S_RDH = 4'd6,
		S_LNK = 4'd7, S_SCAN = 4'd8, S_PHD = 4'd9, S_PFIX = 4'd10,
		S_OUT = 4'd11, S_HWT = 4'd12, S_PWT = 4'd13;

	logic [3:0] st_q;
	logic [CW:0] clr_q;
	logic [NW-1:0] node_q;
	logic [HW-1:0] cost_q;
	logic [BW-1:0] min_q;
	logic [NW:0] nx_q, pv_q, hd_q;
	logic [BW-1:0] ob_q;
	logic head_hit_q;
	logic out_v_q;
	bpq_pkg::rsp_t out_q;

	// bucket head memory
	logic [NW:0] head_mem [COST_LIMIT+1];
	logic [HW-1:0] h_raddr, h_waddr;
	logic [NW:0] h_rdata, h_wdata;
	logic h_we;
	always_ff @(posedge clk) begin
		if (h_we) head_mem[h_waddr] <= h_wdata;
		h_rdata <= head_mem[h_raddr];
	end

	// node memory ports
	logic [NW-1:0] n_raddr, n_waddr;
	logic [NW:0] n_rnext, n_rprev, n_wnext, n_wprev;
	logic [BW-1:0] n_rbkt, n_wbkt;
	logic n_we;
	logic [2:0] n_wmask;
	bpq_node_mem #(.NW(NW), .BW(BW)) u_nodes (
		.clk, .raddr(n_raddr), .rnext(n_rnext), .rprev(n_rprev), .rbkt(n_rbkt),
		.we(n_we), .waddr(n_waddr), .wnext(n_wnext), .wprev(n_wprev),
		.wbkt(n_wbkt), .wmask(n_wmask)
	);

	logic req_ok;
	assign req.ready = (st_q == S_IDLE);
	assign req_ok = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	// result register load when it is free or drains this cycle
	logic res_load;
	assign res_load = (!out_v_q || rsp.ready) &&
		(((st_q == S_SCAN) && (min_q == NOTQ)) || (st_q == S_OUT));

	logic [HW-1:0] ob_idx, min_idx;
	assign ob_idx = ob_q[HW-1:0];
	assign min_idx = min_q[HW-1:0];

	// old bucket head is the pushed node
	logic head_hit;
	assign head_hit = (h_rdata == {1'b0, node_q});

	// memory port steering
	always_comb begin
		h_raddr = cost_q;
		h_waddr = ob_idx;
		h_wdata = nx_q;
		h_we = 1'b0;
		n_raddr = node_q;
		n_waddr = node_q;
		n_wnext = NONE;
		n_wprev = NONE;
		n_wbkt = NOTQ;
		n_we = 1'b0;
		n_wmask = 3'b000;
		unique case (st_q)
			S_CLR: begin
				h_waddr = clr_q[HW-1:0];
				h_wdata = NONE;
				h_we = (clr_q <= (CW+1)'(COST_LIMIT));
				n_waddr = clr_q[NW-1:0];
				n_we = (clr_q <= (CW+1)'(NODES - 1));
				n_wmask = 3'b100;
			end
			S_IDLE: begin
				n_raddr = req.data.node_id[NW-1:0];
				h_raddr = min_idx;
			end
			S_RDN: h_raddr = n_rbkt[HW-1:0];
			S_UNL: begin
				// head case: new head is next
				h_we = head_hit;
			end
			S_FIXA: begin
				n_waddr = nx_q[NW-1:0];
				n_wprev = head_hit_q ? NONE : pv_q;
				n_we = !nx_q[NW];
				n_wmask = 3'b010;
			end
			S_FIXB: begin
				n_waddr = pv_q[NW-1:0];
				n_wnext = nx_q;
				n_we = !head_hit_q && !pv_q[NW];
				n_wmask = 3'b001;
			end
			S_RDH: h_raddr = cost_q;
			S_HWT: begin
				// present head gets the pushed node as prev
				h_raddr = cost_q;
				n_waddr = h_rdata[NW-1:0];
				n_wprev = {1'b0, node_q};
				n_we = !h_rdata[NW];
				n_wmask = 3'b010;
			end
			S_LNK: begin
				n_wnext = hd_q;
				n_wbkt = BW'(cost_q);
				n_we = 1'b1;
				n_wmask = 3'b111;
				h_waddr = cost_q;
				h_wdata = {1'b0, node_q};
				h_we = 1'b1;
			end
			// read ahead the bucket after the present one
			S_SCAN: h_raddr = min_idx + 1'b1;
			S_PHD: n_raddr = hd_q[NW-1:0];
			S_PWT: n_raddr = hd_q[NW-1:0];
			S_PFIX: begin
				h_waddr = min_idx;
				h_wdata = n_rnext;
				h_we = 1'b1;
				n_waddr = hd_q[NW-1:0];
				n_we = 1'b1;
				n_wmask = 3'b111;
			end
			S_OUT: begin
				n_waddr = nx_q[NW-1:0];
				n_wprev = NONE;
				n_we = !nx_q[NW];
				n_wmask = 3'b010;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			min_q <= NOTQ;
			out_v_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && !res_load) out_v_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q >= (CW+1)'(NODES - 1) && clr_q >= (CW+1)'(COST_LIMIT))
						st_q <= S_IDLE;
				end
				S_IDLE: if (req_ok) begin
					if (req.data.kind == bpq_pkg::KIND_POP) begin
						st_q <= S_SCAN;
					end else if (32'(req.data.node_id) >= NODES ||
						32'(req.data.cost) > COST_LIMIT) begin
						st_q <= S_IDLE;
					end else begin
						st_q <= S_RDN;
					end
				end
				S_RDN: begin
					nx_q <= n_rnext;
					pv_q <= n_rprev;
					ob_q <= n_rbkt;
					st_q <= (n_rbkt == NOTQ) ? S_RDH : S_UNL;
				end
				S_UNL: st_q <= S_FIXA;
				S_FIXA: st_q <= S_FIXB;
				S_FIXB: st_q <= S_RDH;
				S_RDH: st_q <= S_HWT;
				S_HWT: begin
					hd_q <= h_rdata;
					st_q <= S_LNK;
				end
				S_LNK: begin
					st_q <= S_IDLE;
					if (min_q > BW'(cost_q)) min_q <= BW'(cost_q);
				end
				S_SCAN: begin
					if (min_q == NOTQ) begin
						if (res_load) begin
							out_q <= '0;
							out_v_q <= 1'b1;
							st_q <= S_IDLE;
						end
					end else if (!h_rdata[NW]) begin
						hd_q <= h_rdata;
						st_q <= S_PHD;
					end else begin
						min_q <= min_q + 1'b1;
					end
				end
				S_PHD: st_q <= S_PWT;
				S_PWT: st_q <= S_PFIX;
				S_PFIX: begin
					nx_q <= n_rnext;
					st_q <= S_OUT;
				end
				S_OUT: if (res_load) begin
					out_q.found <= 1'b1;
					out_q.out_node <= bpq_pkg::NODE_W'(hd_q[NW-1:0]);
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// request payload and head compare
	always_ff @(posedge clk) begin
		if (req_ok) begin
			node_q <= req.data.node_id[NW-1:0];
			cost_q <= req.data.cost[HW-1:0];
		end
		if (st_q == S_UNL) head_hit_q <= head_hit;
	end

`ifndef SYNTHESIS
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !req.ready) else $error("request taken while busy");
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT) |=> rsp.valid) else $error("pop lost result");
	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= NOTQ) else $error("min pointer out of range");
	a_found_node: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.found) |-> (rsp.data.out_node == '0))
		else $error("empty pop with node");
`endif
endmodule

[tb/bucket_priority_queue_test.sv]
// testbench for the bucket priority queue: directed and random push/pop traffic with prediction
module bucket_priority_queue_test;
	localparam int COST_LIMIT = 1023;
	localparam int NODES = 4096;
	localparam int NOT_QUEUED = COST_LIMIT + 1;
	localparam int NO_NODE = NODES;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	bpq_if #(.T(bpq_pkg::req_t)) req ();
	bpq_if #(.T(bpq_pkg::rsp_t)) rsp ();

	bucket_priority_queue #(.COST_LIMIT(COST_LIMIT), .NODES(NODES)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// predictor state
	int head_of[COST_LIMIT+1];
	int next_of[NODES];
	int prev_of[NODES];
	int bucket_of[NODES];
	int scan_from;

	bpq_pkg::req_t pending_reqs[$];
	bpq_pkg::rsp_t expected_pops[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_recv;
	bit gate_send;
	int idle_cycles;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void unlink_node(input int n);
		int b;
		int nx;
		int pv;
		b = bucket_of[n];
		if (b > COST_LIMIT)
			return;
		nx = next_of[n];
		pv = prev_of[n];
		if (head_of[b] == n) begin
			head_of[b] = nx;
			if (nx < NO_NODE)
				prev_of[nx] = NO_NODE;
		end else begin
			if (pv < NO_NODE)
				next_of[pv] = nx;
			if (nx < NO_NODE)
				prev_of[nx] = pv;
		end
		bucket_of[n] = NOT_QUEUED;
	endfunction

	// apply one accepted request to the predicted queue
	function automatic void predict_request(input bpq_pkg::req_t r);
		int n;
		int c;
		int h;
		bpq_pkg::rsp_t res;
		n = r.node_id;
		c = r.cost;
		if (r.kind == bpq_pkg::KIND_PUSH) begin
			unlink_node(n);
			h = head_of[c];
			next_of[n] = h;
			prev_of[n] = NO_NODE;
			if (h < NO_NODE)
				prev_of[h] = n;
			head_of[c] = n;
			bucket_of[n] = c;
			if (scan_from > c)
				scan_from = c;
			return;
		end
		res = '0;
		while (scan_from <= COST_LIMIT) begin
			h = head_of[scan_from];
			if (h < NO_NODE) begin
				head_of[scan_from] = next_of[h];
				if (next_of[h] < NO_NODE)
					prev_of[next_of[h]] = NO_NODE;
				next_of[h] = NO_NODE;
				prev_of[h] = NO_NODE;
				bucket_of[h] = NOT_QUEUED;
				res.found = 1'b1;
				res.out_node = h[bpq_pkg::NODE_W-1:0];
				break;
			end
			scan_from++;
		end
		expected_pops.push_back(res);
	endfunction

	function automatic bpq_pkg::req_t make_req(input logic k, input int n, input int c);
		bpq_pkg::req_t r;
		r.kind = k;
		r.node_id = n[bpq_pkg::NODE_W-1:0];
		r.cost = c[bpq_pkg::COST_W-1:0];
		return r;
	endfunction

	// mostly low costs and a small node pool so buckets hold lists and requeues happen
	function automatic bpq_pkg::req_t random_req();
		int n;
		int c;
		if ($urandom_range(99) < 45)
			return make_req(bpq_pkg::KIND_POP, $urandom, $urandom);
		n = ($urandom_range(9) == 0) ? $urandom_range(NODES - 1) : $urandom_range(63);
		c = ($urandom_range(9) == 0) ? $urandom_range(COST_LIMIT) : $urandom_range(15);
		return make_req(bpq_pkg::KIND_PUSH, n, c);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid && req.ready)
				void'(pending_reqs.pop_front());
			if (pending_reqs.size() > ((req.valid && req.ready) ? 1 : 0) && !gate_send
					&& $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.data <= pending_reqs[(req.valid && req.ready) ? 1 : 0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver stall control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				predict_request(req.data);
			if (rsp.valid && rsp.ready) begin
				if (expected_pops.size() == 0) begin
					report($sformatf("unexpected result %p", rsp.data));
				end else begin
					bpq_pkg::rsp_t e;
					e = expected_pops.pop_front();
					if (rsp.data.found !== e.found)
						report($sformatf("found %b exp %b", rsp.data.found, e.found));
					if (rsp.data.out_node !== e.out_node)
						report($sformatf("out_node %0d exp %0d",
							rsp.data.out_node, e.out_node));
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_recv
				|| (pending_reqs.size() == 0 && expected_pops.size() == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_pops.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_random(input int count);
		repeat (count)
			pending_reqs.push_back(random_req());
	endtask

	initial begin
		int i;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b0;
		gate_send = 1'b0;
		foreach (head_of[k])
			head_of[k] = NO_NODE;
		foreach (bucket_of[k]) begin
			bucket_of[k] = NOT_QUEUED;
			next_of[k] = 0;
			prev_of[k] = 0;
		end
		scan_from = NOT_QUEUED;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, extremes, same bucket again, requeue, list middle removal
		pending_reqs.push_back(make_req(bpq_pkg::KIND_POP, 0, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 4095, 1023));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 0, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 1, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 2, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 1, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 0, 5));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 2, 1023));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 2730, 682));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 1365, 341));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_POP, 4095, 1023));
		for (i = 0; i < 7; i++)
			pending_reqs.push_back(make_req(bpq_pkg::KIND_POP, 0, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_PUSH, 7, 3));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_POP, 0, 0));
		pending_reqs.push_back(make_req(bpq_pkg::KIND_POP, 0, 0));
		wait_drained();

		// random phases with different idling
		add_random(400);
		wait_drained();
		send_idle_pct = 74;
		add_random(350);
		wait_drained();
		recv_stall_pct = 74;
		send_idle_pct = 0;
		add_random(350);
		wait_drained();
		send_idle_pct = 37;
		recv_stall_pct = 37;
		add_random(350);
		wait_drained();

		// long receiver hold-off while requests keep coming, then sender pause
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b1;
		add_random(150);
		repeat (400) @(posedge clk);
		hold_recv = 1'b0;
		wait_drained();
		gate_send = 1'b1;
		add_random(50);
		repeat (50) @(posedge clk);
		gate_send = 1'b0;
		wait_drained();
		add_random(300);
		wait_drained();

		repeat (1100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
